// File: rtl/egd_pkg.sv
package egd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned RUN_W        = 5;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam logic [RUN_W-1:0] LIMIT_RESET = RUN_W'(20);
  localparam logic [CODE_W-1:0] ACC_SEED   = CODE_W'(1);
  localparam logic [POS_W-1:0] LAST_POS    = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_start;
    logic [POS_W-1:0]  first_pos;
  } entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic              prefix_error;
  } result_t;

endpackage

// File: rtl/egd_front.sv
module egd_front
  import egd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               stream_start,
  input  logic [POS_W-1:0]   skip_bits,
  output logic               q_valid,
  output entry_t             q_entry,
  input  logic               q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  entry_t             new_entry;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_entry  = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // first bit to decode is fixed at accept time
  always_comb begin
    new_entry.data_byte    = data_byte;
    new_entry.stream_start = stream_start;
    new_entry.first_pos    = stream_start ? skip_bits : '0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/egd_back.sv
module egd_back
  import egd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [RUN_W-1:0]   max_prefix_zeros,
  input  logic               q_valid,
  input  entry_t             q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CODE_W-1:0]  code_value,
  output logic               prefix_error,
  output logic               last_of_byte
);

  logic               reading_suffix, reading_suffix_next;
  logic [RUN_W-1:0]   zero_run, zero_run_next;
  logic [RUN_W-1:0]   suffix_left, suffix_left_next;
  logic [CODE_W-1:0]  code_accumulator, code_accumulator_next;
  logic [POS_W-1:0]   bit_pos;
  logic               fresh;

  result_t            hold;
  logic               hold_valid;
  logic               hold_final;

  logic               cur_rs;
  logic [RUN_W-1:0]   cur_zr;
  logic [RUN_W-1:0]   cur_sl;
  logic [CODE_W-1:0]  cur_acc;
  logic [POS_W-1:0]   cur_pos;
  logic               cur_bit;
  logic               eob;
  logic               res_hit;
  result_t            res_new;
  logic [CODE_W-1:0]  acc_shift;
  logic [RUN_W-1:0]   sl_dec;
  logic               out_free;
  logic               step_needs_emit;
  logic               do_step;
  logic               emit;
  logic               emit_last;

  always_comb begin
    cur_pos = fresh ? q_entry.first_pos : bit_pos;
    if (fresh && q_entry.stream_start) begin
      cur_rs  = 1'b0;
      cur_zr  = '0;
      cur_sl  = '0;
      cur_acc = ACC_SEED;
    end else begin
      cur_rs  = reading_suffix;
      cur_zr  = zero_run;
      cur_sl  = suffix_left;
      cur_acc = code_accumulator;
    end
    cur_bit   = q_entry.data_byte[LAST_POS - cur_pos];
    eob       = (cur_pos == LAST_POS);
    acc_shift = {cur_acc[CODE_W-2:0], cur_bit};
    sl_dec    = cur_sl - RUN_W'(1);

    reading_suffix_next   = cur_rs;
    zero_run_next         = cur_zr;
    suffix_left_next      = cur_sl;
    code_accumulator_next = cur_acc;
    res_hit               = 1'b0;
    res_new.code_value    = '0;
    res_new.prefix_error  = 1'b0;

    if (!cur_rs) begin
      if (!cur_bit) begin
        if (cur_zr >= max_prefix_zeros) begin
          res_hit              = 1'b1;
          res_new.prefix_error = 1'b1;
          zero_run_next        = '0;
        end else begin
          zero_run_next = cur_zr + RUN_W'(1);
        end
      end else if (cur_zr == '0) begin
        res_hit = 1'b1;
      end else begin
        reading_suffix_next   = 1'b1;
        suffix_left_next      = cur_zr;
        code_accumulator_next = ACC_SEED;
      end
    end else begin
      code_accumulator_next = acc_shift;
      suffix_left_next      = sl_dec;
      if (sl_dec == '0) begin
        res_hit               = 1'b1;
        res_new.code_value    = acc_shift - ACC_SEED;
        reading_suffix_next   = 1'b0;
        zero_run_next         = '0;
        suffix_left_next      = '0;
        code_accumulator_next = ACC_SEED;
      end
    end

    // the held result goes out once it is known whether it closes its byte
    out_free        = !out_valid || out_ready;
    step_needs_emit = hold_valid && (hold_final || res_hit || eob);
    do_step         = q_valid && (!step_needs_emit || out_free);
    emit            = out_free && hold_valid && (hold_final || (q_valid && (res_hit || eob)));
    emit_last       = hold_final || (!res_hit && eob);
    q_pop           = do_step && eob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_suffix   <= 1'b0;
      zero_run         <= '0;
      suffix_left      <= '0;
      code_accumulator <= ACC_SEED;
      bit_pos          <= '0;
      fresh            <= 1'b1;
      hold_valid       <= 1'b0;
      hold_final       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (do_step) begin
        reading_suffix   <= reading_suffix_next;
        zero_run         <= zero_run_next;
        suffix_left      <= suffix_left_next;
        code_accumulator <= code_accumulator_next;
        fresh            <= eob;
        bit_pos          <= cur_pos + POS_W'(1);
      end
      if (do_step && res_hit) begin
        hold_valid <= 1'b1;
        hold_final <= eob;
      end else if (emit) begin
        hold_valid <= 1'b0;
        hold_final <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && res_hit) begin
      hold <= res_new;
    end
    if (emit) begin
      code_value   <= hold.code_value;
      prefix_error <= hold.prefix_error;
      last_of_byte <= emit_last;
    end
  end

endmodule

// File: rtl/exp_golomb_stream_decoder_core.sv
// Unsigned Exp-Golomb ue(v) decoder for a byte stream, MSB first. Bytes are
// taken into a short queue and decoded one bit per clock while the output
// is not stalled; the bit-serial decode loop sets this rate, and input is
// accepted while the queue has room. Each result is held until the next
// result or the end of its byte is known, so last_of_byte can be set on the
// final result of its byte; up to eight results leave per byte, one per
// cycle while out_ready is high, through a registered output. An error
// result (value 0) is given when a zero run exceeds max_prefix_zeros. Write
// max_prefix_zeros only when the decoder is idle.
module exp_golomb_stream_decoder_core
  import egd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               stream_start,
  input  logic [POS_W-1:0]   skip_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CODE_W-1:0]  code_value,
  output logic               prefix_error,
  output logic               last_of_byte,
  input  logic               cfg_we,
  input  logic [RUN_W-1:0]   cfg_wdata
);

  logic [RUN_W-1:0] max_prefix_zeros;
  logic             q_valid;
  entry_t           q_entry;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_prefix_zeros <= LIMIT_RESET;
    end else if (cfg_we) begin
      max_prefix_zeros <= cfg_wdata;
    end
  end

  egd_front #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_start (stream_start),
    .skip_bits    (skip_bits),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  egd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .max_prefix_zeros (max_prefix_zeros),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .code_value       (code_value),
    .prefix_error     (prefix_error),
    .last_of_byte     (last_of_byte)
  );

endmodule

// File: test/exp_golomb_stream_decoder_core_test.sv
module exp_golomb_stream_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import egd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic [POS_W-1:0]  skip;
  } stream_byte_t;

  typedef struct packed {
    logic [CODE_W-1:0] value;
    logic              err;
    logic              last;
  } decoded_code_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              stream_start = 1'b0;
  logic [POS_W-1:0]  skip_bits = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] code_value;
  logic              prefix_error;
  logic              last_of_byte;
  logic              cfg_we = 1'b0;
  logic [RUN_W-1:0]  cfg_wdata = '0;

  // decoder image kept alongside the block
  logic [RUN_W-1:0]  run_limit = LIMIT_RESET;
  logic              in_suffix = 1'b0;
  logic [RUN_W-1:0]  zero_count = '0;
  logic [RUN_W-1:0]  bits_left = '0;
  logic [CODE_W-1:0] code_acc = ACC_SEED;

  stream_byte_t  pending_bytes[$];
  decoded_code_t pending_codes[$];
  stream_byte_t  next_byte;
  decoded_code_t want;

  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;

  exp_golomb_stream_decoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_start (stream_start),
    .skip_bits    (skip_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_value   (code_value),
    .prefix_error (prefix_error),
    .last_of_byte (last_of_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void clear_decoder();
    in_suffix  = 1'b0;
    zero_count = '0;
    bits_left  = '0;
    code_acc   = ACC_SEED;
  endfunction

  function automatic void expect_code(logic [CODE_W-1:0] value, logic err);
    decoded_code_t c;
    c.value = value;
    c.err   = err;
    c.last  = 1'b0;
    pending_codes.insert(pending_codes.size(), c);
  endfunction

  function automatic void decode_stream_byte(stream_byte_t sb);
    int unsigned pos;
    int unsigned count_before;
    logic        b;
    count_before = pending_codes.size();
    pos = 0;
    if (sb.start) begin
      clear_decoder();
      pos = int'(sb.skip);
    end
    for (; pos < 8; pos++) begin
      b = sb.data[7 - pos];
      if (!in_suffix) begin
        if (!b) begin
          if (zero_count >= run_limit) begin
            expect_code('0, 1'b1);
            zero_count = '0;
          end else begin
            zero_count = zero_count + RUN_W'(1);
          end
        end else if (zero_count == '0) begin
          expect_code('0, 1'b0);
        end else begin
          in_suffix = 1'b1;
          bits_left = zero_count;
          code_acc  = ACC_SEED;
        end
      end else begin
        code_acc  = {code_acc[CODE_W-2:0], b};
        bits_left = bits_left - RUN_W'(1);
        if (bits_left == '0) begin
          expect_code(code_acc - CODE_W'(1), 1'b0);
          clear_decoder();
        end
      end
    end
    if (pending_codes.size() > count_before) begin
      pending_codes[pending_codes.size() - 1].last = 1'b1;
    end
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_stream_byte({data_byte, stream_start, skip_bits});
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_valid     <= 1'b1;
          data_byte    <= next_byte.data;
          stream_start <= next_byte.start;
          skip_bits    <= next_byte.skip;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
          end
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1, 2: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(8, 24);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes every so often
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_codes.size() == 0) begin
          log_error($sformatf("unexpected transaction: value %0d err %0b last %0b",
                              code_value, prefix_error, last_of_byte));
        end else begin
          want = pending_codes.pop_front();
          if (code_value !== want.value || prefix_error !== want.err ||
              last_of_byte !== want.last) begin
            log_error($sformatf(
              "mismatch: expected value %0d err %0b last %0b, got value %0d err %0b last %0b",
              want.value, want.err, want.last, code_value, prefix_error, last_of_byte));
          end
        end
      end
      stall_tick++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ((stall_tick % 8) < 3);
      endcase
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || pending_codes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= RUN_W'(v);
    run_limit = RUN_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] d, logic s, logic [POS_W-1:0] k);
    stream_byte_t sb;
    sb.data  = d;
    sb.start = s;
    sb.skip  = k;
    pending_bytes.insert(pending_bytes.size(), sb);
  endtask

  // mostly well-formed codes, some over-long zero runs and noise
  task automatic queue_coded_bytes(int unsigned n_bytes);
    bit          bitq[$];
    int unsigned kind;
    int unsigned nz;
    int unsigned i;
    bit          first;
    stream_byte_t sb;
    while (bitq.size() < n_bytes * 8) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if (kind <= 3) begin
          nz = $urandom_range(0, (run_limit < 3) ? int'(run_limit) : 3);
        end else begin
          nz = $urandom_range(0, int'(run_limit));
        end
        repeat (nz) bitq.insert(bitq.size(), 1'b0);
        bitq.insert(bitq.size(), 1'b1);
        repeat (nz) bitq.insert(bitq.size(), bit'($urandom_range(0, 1)));
      end else if (kind == 7) begin
        repeat (int'(run_limit) + 1) bitq.insert(bitq.size(), 1'b0);
      end else begin
        repeat (8) bitq.insert(bitq.size(), bit'($urandom_range(0, 1)));
      end
    end
    while (bitq.size() % 8 != 0) begin
      bitq.insert(bitq.size(), bit'($urandom_range(0, 1)));
    end
    first = 1'b1;
    while (bitq.size() != 0) begin
      for (i = 0; i < 8; i++) begin
        sb.data[7 - i] = bitq.pop_front();
      end
      sb.skip  = POS_W'($urandom_range(0, 7));
      sb.start = ($urandom_range(0, 19) == 0);
      if (first) begin
        sb.start = 1'b1;
        sb.skip  = '0;
      end
      first = 1'b0;
      pending_bytes.insert(pending_bytes.size(), sb);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit: empty prefixes, skip with and without start, run overflow
    push_byte(8'hFF, 1'b1, 3'd0);
    push_byte(8'hFF, 1'b1, 3'd7);
    push_byte(8'hA5, 1'b0, 3'd5);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h00, 1'b1, 3'd3);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h00, 1'b0, 3'd0);

    // lower the limit; a new zero run then overflows it, then codes follow
    set_limit(5);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h4B, 1'b0, 3'd0);

    // longest code, largest value
    set_limit(31);
    push_byte(8'h00, 1'b1, 3'd0);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h01, 1'b0, 3'd0);
    push_byte(8'hFF, 1'b0, 3'd0);
    push_byte(8'hFF, 1'b0, 3'd0);
    push_byte(8'hFF, 1'b0, 3'd0);
    push_byte(8'hFE, 1'b0, 3'd0);

    // every zero is an error
    set_limit(0);
    push_byte(8'h00, 1'b0, 3'd0);
    push_byte(8'h55, 1'b0, 3'd0);
    push_byte(8'hFF, 1'b0, 3'd0);

    set_limit(1);
    push_byte(8'h21, 1'b1, 3'd2);
    push_byte(8'h9C, 1'b0, 3'd0);

    set_limit(31);
    queue_coded_bytes(19);
    set_limit(1);
    queue_coded_bytes(19);
    set_limit($urandom_range(2, 30));
    queue_coded_bytes(19);
    set_limit($urandom_range(1, 31));
    queue_coded_bytes(19);
    set_limit(20);
    queue_coded_bytes(19);

    wait_idle();
    if (pending_codes.size() != 0) begin
      log_error($sformatf("%0d expected transactions never arrived", pending_codes.size()));
    end
    if (error_count == 0) begin
      $display("exp_golomb_stream_decoder_core_test: clean");
    end else begin
      $display("exp_golomb_stream_decoder_core_test: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("exp_golomb_stream_decoder_core_test: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/egd_pkg.sv
rtl/egd_front.sv
rtl/egd_back.sv
rtl/exp_golomb_stream_decoder_core.sv
test/exp_golomb_stream_decoder_core_test.sv
